// ===== rtl/bfr_pkg.sv =====
`default_nettype none

package bfr_pkg;

  // Fixed field widths of the stream payloads.
  localparam int CountW   = 5;
  localparam int DataW    = 8;
  localparam int TdataW   = 16;

  // Defaults for the top-level parameters.
  localparam int DepthDefault       = 16;
  localparam int ElementBitsDefault = 8;

  // Largest number of data beats that one read request may produce.
  localparam int MaxResults = 16;

  // Capacity register value after reset.
  localparam logic [CountW-1:0] CapReset = 5'd16;

  // Input selector codes (s_tuser).
  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  // Output kind codes (m_tuser).
  localparam logic KindStatus = 1'b0;
  localparam logic KindRead   = 1'b1;

  // Status codes.
  localparam logic StatAccepted = 1'b0;
  localparam logic StatRejected = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/bfr_ram.sv =====
`default_nettype none

module bfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bfr_alu.sv =====
`default_nettype none

// Shared subtractor: gives a - b and the borrow, which is set when a < b.
module bfr_alu #(
  parameter int WIDTH = 5
) (
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  output logic      [WIDTH-1:0] diff_o,
  output logic                  borrow_o
);

  logic [WIDTH:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[WIDTH-1:0];
  assign borrow_o = full[WIDTH];

endmodule

`default_nettype wire

// ===== rtl/burst_ring_fifo.sv =====
// Ring FIFO with burst writes and burst reads, driven by a small sequencer.
// A write element passes the idle and position states, the first of a burst also
// the room and clip states where the shared subtractor sizes it. A read request
// passes idle and compare, then address and data per element (registered read).
// One item is in work at a time and the output register lets a result wait.
// Reset (async, active low): pointers, fill, burst state to zero, capacity to 16.
`default_nettype none

module burst_ring_fifo #(
  parameter int DEPTH        = bfr_pkg::DepthDefault,
  parameter int ELEMENT_BITS = bfr_pkg::ElementBitsDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration: capacity register.
  input  wire logic                        cfg_we_i,
  input  wire logic [bfr_pkg::CountW-1:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic                        s_tvalid_i,
  output logic                             s_tready_o,
  // [0] all_or_nothing, [5:1] burst_length, [13:6] data_in, [15:14] zero
  input  wire logic [bfr_pkg::TdataW-1:0]  s_tdata_i,
  input  wire logic                        s_tlast_i,  // last_in
  input  wire logic                        s_tuser_i,  // [0] opcode
  // Output stream.
  output logic                             m_tvalid_o,
  input  wire logic                        m_tready_i,
  // [0] status, [5:1] count, [13:6] data_out, [15:14] zero
  output logic      [bfr_pkg::TdataW-1:0]  m_tdata_o,
  output logic                             m_tlast_o,  // last_out
  output logic                             m_tuser_o   // [0] kind
);

  localparam int CW = bfr_pkg::CountW;
  localparam int PW = $clog2(DEPTH);
  // Level width: must hold DEPTH itself and any 5-bit length.
  localparam int LW = ($clog2(DEPTH + 1) > CW) ? $clog2(DEPTH + 1) : CW;
  localparam logic [CW-1:0] PosMax = {CW{1'b1}};

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWRoom = 3'd1;
  localparam logic [2:0] StWClip = 3'd2;
  localparam logic [2:0] StWPos  = 3'd3;
  localparam logic [2:0] StRCmp  = 3'd4;
  localparam logic [2:0] StRAddr = 3'd5;
  localparam logic [2:0] StRData = 3'd6;

  logic [2:0]    state_q, state_d;

  logic [CW-1:0] cap_q;
  logic [PW-1:0] wp_q, rp_q;
  logic [LW-1:0] fill_q;
  logic          bact_q;
  logic          brej_q;
  logic [CW-1:0] bacc_q;
  logic [CW-1:0] bpos_q;
  logic [LW-1:0] room_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] idx_q;

  // Latched input item.
  logic          aon_q;
  logic [CW-1:0] len_q;
  logic [bfr_pkg::DataW-1:0] din_q;
  logic          last_q;

  // Output register.
  logic          m_valid_q;
  logic          m_kind_q, m_status_q, m_last_q;
  logic [CW-1:0] m_count_q;
  logic [bfr_pkg::DataW-1:0] m_data_q;

  logic s_acc;
  logic out_free;
  assign s_tready_o = (state_q == StIdle);
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;

  // Effective capacity: zero acts as one, anything above DEPTH as DEPTH.
  logic [LW-1:0] cap_ext, eff_cap;
  assign cap_ext = LW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = LW'(1);
    end else if (cap_ext > LW'(DEPTH)) begin
      eff_cap = LW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Pointer advance with wrap at the effective capacity.
  logic [LW-1:0] wp_inc, rp_inc;
  logic [PW-1:0] wp_next, rp_next;
  assign wp_inc  = LW'(wp_q) + LW'(1);
  assign rp_inc  = LW'(rp_q) + LW'(1);
  assign wp_next = (wp_inc >= eff_cap) ? '0 : wp_inc[PW-1:0];
  assign rp_next = (rp_inc >= eff_cap) ? '0 : rp_inc[PW-1:0];

  // Shared subtractor and its operand selection.
  logic [LW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_borrow;

  always_comb begin
    alu_a = fill_q;
    alu_b = LW'(len_q);
    unique case (state_q)
      StWRoom: begin
        alu_a = eff_cap;
        alu_b = fill_q;
      end
      StWClip: begin
        alu_a = room_q;
        alu_b = LW'(len_q);
      end
      StWPos: begin
        alu_a = LW'(bpos_q);
        alu_b = LW'(bacc_q);
      end
      StRData: begin
        alu_a = fill_q;
        alu_b = LW'(n_q);
      end
      default: begin
        alu_a = fill_q;
        alu_b = LW'(len_q);
      end
    endcase
  end

  bfr_alu #(
    .WIDTH (LW)
  ) u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  // Read count after clipping to the stored level and the result limit.
  logic [LW-1:0] rd_sel;
  logic [CW-1:0] rd_n;
  assign rd_sel = alu_borrow ? fill_q : LW'(len_q);
  assign rd_n   = (rd_sel > LW'(bfr_pkg::MaxResults)) ? CW'(bfr_pkg::MaxResults)
                                                      : rd_sel[CW-1:0];

  logic          rd_last;
  assign rd_last = (CW'(idx_q + CW'(1)) == n_q);

  // Storage.
  logic                    ram_we, ram_re;
  logic [ELEMENT_BITS-1:0] ram_rdata;

  bfr_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ELEMENT_BITS'(din_q)),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer control. A step that produces a result waits, with nothing
  // changed, until the output register can take it.
  logic          emit;
  logic          e_kind, e_status, e_last;
  logic [CW-1:0] e_count;
  logic [bfr_pkg::DataW-1:0] e_data;
  logic          w_go, w_store;

  assign w_go    = !last_q || out_free;
  assign w_store = alu_borrow;  // position below accepted count

  always_comb begin
    state_d  = state_q;
    emit     = 1'b0;
    e_kind   = bfr_pkg::KindStatus;
    e_status = bfr_pkg::StatAccepted;
    e_count  = '0;
    e_data   = '0;
    e_last   = 1'b1;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          if (s_tuser_i == bfr_pkg::OpRead) begin
            state_d = StRCmp;
          end else if (bact_q) begin
            state_d = StWPos;
          end else begin
            state_d = StWRoom;
          end
        end
      end
      StWRoom: begin
        state_d = StWClip;
      end
      StWClip: begin
        state_d = StWPos;
      end
      StWPos: begin
        if (w_go) begin
          ram_we = w_store;
          if (last_q) begin
            emit     = 1'b1;
            e_kind   = bfr_pkg::KindStatus;
            e_status = brej_q ? bfr_pkg::StatRejected : bfr_pkg::StatAccepted;
            e_count  = bacc_q;
          end
          state_d = StIdle;
        end
      end
      StRCmp: begin
        if (aon_q && alu_borrow) begin
          if (out_free) begin
            emit     = 1'b1;
            e_kind   = bfr_pkg::KindRead;
            e_status = bfr_pkg::StatRejected;
            state_d  = StIdle;
          end
        end else if (rd_n == '0) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = bfr_pkg::KindRead;
            state_d = StIdle;
          end
        end else begin
          state_d = StRAddr;
        end
      end
      StRAddr: begin
        ram_re  = 1'b1;
        state_d = StRData;
      end
      StRData: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = bfr_pkg::KindRead;
          e_count = n_q;
          e_data  = ram_rdata[bfr_pkg::DataW-1:0];
          e_last  = rd_last;
          state_d = rd_last ? StIdle : StRAddr;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= bfr_pkg::CapReset;
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      bact_q  <= 1'b0;
      brej_q  <= 1'b0;
      bacc_q  <= '0;
      bpos_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // A new capacity empties the FIFO and drops any open write burst.
        cap_q  <= cfg_wdata_i;
        wp_q   <= '0;
        rp_q   <= '0;
        fill_q <= '0;
        bact_q <= 1'b0;
        brej_q <= 1'b0;
        bacc_q <= '0;
        bpos_q <= '0;
      end else begin
        unique case (state_q)
          StWClip: begin
            bact_q <= 1'b1;
            bpos_q <= '0;
            if (!alu_borrow) begin
              bacc_q <= len_q;
              brej_q <= 1'b0;
            end else if (aon_q) begin
              bacc_q <= '0;
              brej_q <= 1'b1;
            end else begin
              // Room is below the length here, so it fits the count width.
              bacc_q <= room_q[CW-1:0];
              brej_q <= 1'b0;
            end
          end
          StWPos: begin
            if (w_go) begin
              if (w_store) begin
                wp_q   <= wp_next;
                fill_q <= fill_q + LW'(1);
              end
              if (last_q) begin
                bact_q <= 1'b0;
                brej_q <= 1'b0;
                bacc_q <= '0;
                bpos_q <= '0;
              end else if (bpos_q != PosMax) begin
                bpos_q <= bpos_q + CW'(1);
              end
            end
          end
          StRData: begin
            if (out_free) begin
              rp_q <= rp_next;
              if (rd_last) begin
                fill_q <= alu_diff;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      aon_q  <= s_tdata_i[0];
      len_q  <= s_tdata_i[5:1];
      din_q  <= s_tdata_i[13:6];
      last_q <= s_tlast_i;
    end
    if (state_q == StWRoom) begin
      room_q <= alu_diff;
    end
    if (state_q == StRCmp) begin
      n_q   <= rd_n;
      idx_q <= '0;
    end else if (state_q == StRData && out_free) begin
      idx_q <= idx_q + CW'(1);
    end
  end

  // Output register: loads whenever it is empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_kind_q   <= e_kind;
      m_status_q <= e_status;
      m_count_q  <= e_count;
      m_data_q   <= e_data;
      m_last_q   <= e_last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {2'b00, m_data_q, m_count_q, m_status_q};
  assign m_tlast_o  = m_last_q;
  assign m_tuser_o  = m_kind_q;

endmodule

`default_nettype wire

// ===== sim/burst_ring_fifo_tb.sv =====
`timescale 1ns / 100ps

module burst_ring_fifo_tb;
  import bfr_pkg::*;

  // One input beat and one output beat, field by field.
  typedef struct packed {
    logic              op;
    logic              aon;
    logic [CountW-1:0] len;
    logic [DataW-1:0]  data;
    logic              last;
  } fifo_item_t;

  typedef struct packed {
    logic              kind;
    logic              status;
    logic [CountW-1:0] count;
    logic [DataW-1:0]  data;
    logic              last;
  } fifo_beat_t;

  // A row of the directed table: either a capacity write or an input beat,
  // optionally with its single result written out by hand.
  typedef struct packed {
    bit                is_cfg;
    logic [CountW-1:0] cap;
    bit                typed;
    fifo_item_t        item;
    fifo_beat_t        want;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              s_tvalid_i  = 1'b0;
  logic              s_tready_o;
  logic [TdataW-1:0] s_tdata_i   = '0;
  logic              s_tlast_i   = 1'b0;
  logic              s_tuser_i   = 1'b0;
  logic              m_tvalid_o;
  logic              m_tready_i  = 1'b0;
  logic [TdataW-1:0] m_tdata_o;
  logic              m_tlast_o;
  logic              m_tuser_o;

  burst_ring_fifo DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the FIFO used to predict every output beat.
  logic [DataW-1:0]  shadow_mem [16];
  logic [CountW-1:0] cap_q;
  logic [3:0]        wr_q;
  logic [3:0]        rd_q;
  logic [CountW-1:0] fill_q;
  logic [CountW-1:0] acc_q;
  logic [CountW-1:0] pos_q;
  bit                open_q;
  bit                rej_q;

  fifo_beat_t expected_beats[$];
  fifo_beat_t fresh_beats[$];
  stim_row_t  dir_table[$];

  int errors     = 0;
  int items_sent = 0;
  int hold_req   = 0;
  bit tx_fast    = 1'b0;
  bit rx_fast    = 1'b0;

  // Capacity values out of range are folded into 1..16.
  function automatic int eff_cap();
    if (cap_q == 0) return 1;
    if (cap_q > 16) return 16;
    return cap_q;
  endfunction

  function automatic fifo_beat_t mk_beat(logic kind, logic status, logic [CountW-1:0] count,
                                         logic [DataW-1:0] data, logic last);
    fifo_beat_t b;
    b.kind   = kind;
    b.status = status;
    b.count  = count;
    b.data   = data;
    b.last   = last;
    return b;
  endfunction

  function automatic fifo_item_t mk_item(logic op, logic aon, logic [CountW-1:0] len,
                                         logic [DataW-1:0] data, logic last);
    fifo_item_t it;
    it.op   = op;
    it.aon  = aon;
    it.len  = len;
    it.data = data;
    it.last = last;
    return it;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Burst lengths mostly stay near the capacity in use so that both clipping
  // and full acceptance happen often.
  function automatic int pick_len();
    int hi;
    int r;
    hi = eff_cap() + 2;
    if (hi > 16) hi = 16;
    r = $urandom_range(0, 99);
    if (r < 10) return 16;
    if (r < 15) return 0;
    return $urandom_range(1, hi);
  endfunction

  // Emptying the FIFO: pointers and fill level to zero, open burst dropped.
  task automatic drop_contents();
    wr_q   = '0;
    rd_q   = '0;
    fill_q = '0;
    acc_q  = '0;
    pos_q  = '0;
    open_q = 1'b0;
    rej_q  = 1'b0;
  endtask

  // Works out the output beats caused by one accepted input beat and leaves
  // them in fresh_beats.
  task automatic predict_item(input fifo_item_t it);
    int eff;
    int room;
    int n;
    eff = eff_cap();
    fresh_beats.delete();
    if (it.op == OpWrite) begin
      if (!open_q) begin
        room   = (eff > fill_q) ? eff - fill_q : 0;
        open_q = 1'b1;
        pos_q  = '0;
        if (it.len <= room) begin
          acc_q = it.len;
          rej_q = 1'b0;
        end else if (it.aon) begin
          acc_q = '0;
          rej_q = 1'b1;
        end else begin
          acc_q = room;
          rej_q = 1'b0;
        end
      end
      if (pos_q < acc_q && fill_q < eff) begin
        shadow_mem[wr_q] = it.data;
        wr_q   = (wr_q + 1 >= eff) ? 0 : wr_q + 1;
        fill_q = fill_q + 1;
      end
      if (pos_q < 31) pos_q = pos_q + 1;
      if (it.last) begin
        fresh_beats.push_back(mk_beat(KindStatus, rej_q ? StatRejected : StatAccepted,
                                      acc_q, '0, 1'b1));
        open_q = 1'b0;
        rej_q  = 1'b0;
        acc_q  = '0;
        pos_q  = '0;
      end
    end else begin
      if (it.len > fill_q && it.aon) begin
        fresh_beats.push_back(mk_beat(KindRead, StatRejected, '0, '0, 1'b1));
      end else begin
        n = (it.len > fill_q) ? fill_q : it.len;
        if (n > MaxResults) n = MaxResults;
        if (n == 0) begin
          fresh_beats.push_back(mk_beat(KindRead, StatAccepted, '0, '0, 1'b1));
        end
        for (int i = 0; i < n; i++) begin
          fresh_beats.push_back(mk_beat(KindRead, StatAccepted, n, shadow_mem[rd_q],
                                        i + 1 == n));
          rd_q = (rd_q + 1 >= eff) ? 0 : rd_q + 1;
        end
        fill_q = fill_q - n;
      end
    end
  endtask

  // Offers one beat after a random gap and records its expected results once
  // it has been taken.
  task automatic send_item(input fifo_item_t it, input bit typed, input fifo_beat_t want);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= it.op;
    s_tlast_i  <= it.last;
    s_tdata_i  <= {2'b00, it.data, it.len, it.aon};
    do @(posedge clk_i); while (!s_tready_o);
    predict_item(it);
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      foreach (fresh_beats[i]) expected_beats.push_back(fresh_beats[i]);
    end
    items_sent++;
  endtask

  // Holds the input off until every expected beat has come out, then lets
  // the block finish any write element still in flight.
  task automatic wait_drain(input int limit);
    int waited;
    waited = 0;
    s_tvalid_i <= 1'b0;
    while (expected_beats.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
      errors++;
      expected_beats.delete();
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CountW-1:0] value);
    wait_drain(20000);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cap_q = value;
    drop_contents();
  endtask

  task automatic add_cfg(input logic [CountW-1:0] value);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.cap    = value;
    dir_table.push_back(row);
  endtask

  task automatic add_item(input logic op, input logic aon, input logic [CountW-1:0] len,
                          input logic [DataW-1:0] data, input logic last);
    stim_row_t row;
    row      = '0;
    row.item = mk_item(op, aon, len, data, last);
    dir_table.push_back(row);
  endtask

  // Rows whose only result is a status or an empty read: data zero, last set.
  task automatic add_typed(input logic op, input logic aon, input logic [CountW-1:0] len,
                           input logic [DataW-1:0] data, input logic last, input logic kind,
                           input logic status, input logic [CountW-1:0] count);
    stim_row_t row;
    row       = '0;
    row.item  = mk_item(op, aon, len, data, last);
    row.typed = 1'b1;
    row.want  = mk_beat(kind, status, count, '0, 1'b1);
    dir_table.push_back(row);
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off when
  // the stimulus asks for it.
  initial begin
    int         stall;
    fifo_beat_t got;
    fifo_beat_t want;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      got = mk_beat(m_tuser_o, m_tdata_o[0], m_tdata_o[5:1], m_tdata_o[13:6], m_tlast_o);
      if (expected_beats.size() == 0) begin
        $display("%0t: extra beat, expected none, got kind %0d stat %0d count %0d data %0d last %0d",
                 $time, got.kind, got.status, got.count, got.data, got.last);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("status", want.status, got.status);
        check_field("count", want.count, got.count);
        check_field("data_out", want.data, got.data);
        check_field("last_out", want.last, got.last);
      end
      if ($urandom_range(0, 19) == 0) rx_fast = !rx_fast;
    end
  end

  initial begin
    int         caps [10];
    int         r;
    int         len;
    int         nel;
    int         hi;
    int         start;
    fifo_beat_t none;

    caps = '{16, 1, 9, 0, 31, 3, 16, 2, 13, 16};
    none = '0;
    cap_q = CapReset;
    drop_contents();

    // Directed part, starting from reset with capacity 16.
    add_typed(OpRead,  1'b1, 5'd1,  8'h00, 1'b0, KindRead,   StatRejected, 5'd0);
    add_typed(OpRead,  1'b0, 5'd16, 8'h00, 1'b0, KindRead,   StatAccepted, 5'd0);
    add_typed(OpRead,  1'b1, 5'd0,  8'h00, 1'b0, KindRead,   StatAccepted, 5'd0);
    add_typed(OpWrite, 1'b1, 5'd0,  8'h3C, 1'b1, KindStatus, StatAccepted, 5'd0);
    // A one-beat burst reports the length it claimed, not what it stored.
    add_typed(OpWrite, 1'b1, 5'd16, 8'hFF, 1'b1, KindStatus, StatAccepted, 5'd16);
    add_item(OpWrite, 1'b0, 5'd3, 8'h00, 1'b0);
    add_item(OpWrite, 1'b0, 5'd3, 8'hAA, 1'b0);
    add_item(OpWrite, 1'b0, 5'd3, 8'h55, 1'b1);
    add_typed(OpRead,  1'b1, 5'd16, 8'h00, 1'b0, KindRead,   StatRejected, 5'd0);
    add_item(OpRead, 1'b1, 5'd4, 8'h00, 1'b0);
    add_cfg(5'd2);
    // Rejected burst: nothing stored, status at the closing beat.
    add_item(OpWrite, 1'b1, 5'd3, 8'h11, 1'b0);
    add_typed(OpWrite, 1'b1, 5'd3,  8'h22, 1'b1, KindStatus, StatRejected, 5'd0);
    // Clipped burst with a read in the middle and an excess beat at the end.
    add_item(OpWrite, 1'b0, 5'd16, 8'h80, 1'b0);
    add_item(OpRead,  1'b0, 5'd1,  8'h00, 1'b0);
    add_item(OpWrite, 1'b0, 5'd16, 8'h7F, 1'b0);
    add_item(OpWrite, 1'b0, 5'd16, 8'h33, 1'b1);
    add_typed(OpRead,  1'b1, 5'd2,  8'h00, 1'b0, KindRead,   StatRejected, 5'd0);
    add_item(OpRead, 1'b0, 5'd2, 8'h00, 1'b0);
    // Capacity zero behaves as one.
    add_cfg(5'd0);
    add_item(OpWrite, 1'b1, 5'd1, 8'h0F, 1'b1);
    add_item(OpWrite, 1'b0, 5'd5, 8'hF0, 1'b1);
    add_item(OpRead,  1'b1, 5'd1, 8'h00, 1'b0);
    // Oversized capacity, then a write that drops the open burst.
    add_cfg(5'd31);
    add_item(OpWrite, 1'b0, 5'd1, 8'h5A, 1'b0);
    add_cfg(5'd16);
    add_typed(OpRead,  1'b0, 5'd16, 8'h00, 1'b0, KindRead,   StatAccepted, 5'd0);
    add_item(OpWrite, 1'b1, 5'd1, 8'hC3, 1'b1);
    add_item(OpRead,  1'b0, 5'd1, 8'h00, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) write_capacity(dir_table[i].cap);
      else send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
    end

    // Random part: one phase per capacity setting, mostly complete bursts
    // and reads, with broken bursts and stray beats mixed in.
    for (int phase = 0; phase < 10; phase++) begin
      write_capacity(caps[phase]);
      if (phase == 6) begin
        // Receiver goes quiet while the sender keeps pushing back to back.
        tx_fast  = 1'b1;
        hold_req = 300;
      end
      start = items_sent;
      while (items_sent - start < 42) begin
        if (phase != 6 && $urandom_range(0, 23) == 0) tx_fast = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if (r < 45) begin
          len = pick_len();
          nel = (len == 0) ? 1 : len;
          if ($urandom_range(0, 6) == 0) nel = $urandom_range(1, len + 3);
          for (int k = 0; k < nel; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0) begin
              send_item(mk_item(OpRead, $urandom_range(0, 1), pick_len(), $urandom_range(0, 255),
                                $urandom_range(0, 1)), 1'b0, none);
            end
            send_item(mk_item(OpWrite, $urandom_range(0, 1) ? 1'b1 : 1'b0, len,
                              $urandom_range(0, 255), k == nel - 1), 1'b0, none);
            // The length is sampled only on the first beat of a burst.
            if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 16);
          end
        end else if (r < 85) begin
          hi = (fill_q + 1 > 16) ? 16 : fill_q + 1;
          len = $urandom_range(0, 1) ? $urandom_range(1, hi) : pick_len();
          send_item(mk_item(OpRead, $urandom_range(0, 1), len, $urandom_range(0, 255),
                            $urandom_range(0, 1)), 1'b0, none);
        end else if (r < 97) begin
          send_item(mk_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 16),
                            $urandom_range(0, 255), $urandom_range(0, 1)), 1'b0, none);
        end else begin
          wait_drain(20000);
        end
      end
      // Sometimes leave a burst open so the capacity write has to drop it.
      if ($urandom_range(0, 2) == 0) begin
        send_item(mk_item(OpWrite, $urandom_range(0, 1), pick_len(), $urandom_range(0, 255),
                          1'b0), 1'b0, none);
      end
    end

    wait_drain(20000);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
